>>> rtl/taylor_sine_cosine_tangent_defines.svh
// Assertion macros for the Taylor sine/cosine/tangent block
`ifndef TAYLOR_SINE_COSINE_TANGENT_DEFINES_SVH
`define TAYLOR_SINE_COSINE_TANGENT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication outside reset
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/tsc_pkg.sv
// Package: widths and series constants for the Taylor sine/cosine/tangent block
`default_nettype none
package tsc_pkg;
	localparam int ANGLE_W = 15;
	localparam int TRIG_W  = 16;
	localparam int TAN_W   = 24;
	localparam int MAG_W   = 32;	// Q.28 term magnitude (value < 16)
	localparam int X2_W    = 29;	// Q.24 square of |x|, up to 4.0^2
	localparam int SUM_W   = 34;	// signed Q.28 running sum
	localparam int Q_W     = 30;	// quotient width of tangent divider
	localparam int TAN_MAX = 8388607;

	// term cell datapath: mag*x2 in Q.52, numerator after the Q.23 drop,
	// reciprocal constant and the two halves of the numerator
	localparam int PROD_W      = MAG_W + X2_W;
	localparam int NUM_W       = PROD_W - 23;
	localparam int RCP_W       = NUM_W + 1;
	localparam int LO_W        = 19;
	localparam int HI_W        = NUM_W - LO_W;
	localparam int PP_W        = HI_W + RCP_W;
	localparam int FULL_W      = NUM_W + RCP_W;
	localparam int CELL_STAGES = 3;

	// divisor k*(k+1) of one series step; Q.24 scale is applied by shift
	function automatic int step_div(input int k);
		return k * (k + 1);
	endfunction

	typedef struct packed {
		logic                     neg;
		logic [ANGLE_W-1:0]       ax;
		logic [X2_W-1:0]          x2;
		logic [MAG_W-1:0]         smag;
		logic [MAG_W-1:0]         cmag;
		logic signed [SUM_W-1:0]  ssum;
		logic signed [SUM_W-1:0]  csum;
	} series_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sine;
		logic signed [TRIG_W-1:0] cosine;
		logic [Q_W-1:0]           rem;
		logic [Q_W-1:0]           quo;
	} div_t;
endpackage
`default_nettype wire

>>> rtl/tsc_if.sv
// Valid/ready channel interface
`default_nettype none
interface tsc_if #(parameter int W = 16) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/tsc_term_cell.sv
// One series cell: next term of each series and its accumulation, three stages
`default_nettype none
module tsc_term_cell #(
	parameter int N      = 1,
	parameter bit DO_SIN = 1'b1,
	parameter bit DO_COS = 1'b1
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire tsc_pkg::series_t d,
	output tsc_pkg::series_t      q
);
	localparam int SKK = tsc_pkg::step_div(2 * N);
	localparam int CKK = tsc_pkg::step_div(2 * N - 1);
	localparam bit ODD = (N % 2) == 1;

	// floor(n / kk) = (n * ceil(2^sh / kk)) >> sh for every n below 2^NUM_W
	localparam int SSH = tsc_pkg::NUM_W + $clog2(SKK);
	localparam int CSH = tsc_pkg::NUM_W + $clog2(CKK);
	localparam longint unsigned SRCP_L = ((64'd1 << SSH) + 64'(SKK) - 64'd1) / 64'(SKK);
	localparam longint unsigned CRCP_L = ((64'd1 << CSH) + 64'(CKK) - 64'd1) / 64'(CKK);
	localparam logic [tsc_pkg::RCP_W-1:0] SRCP = tsc_pkg::RCP_W'(SRCP_L);
	localparam logic [tsc_pkg::RCP_W-1:0] CRCP = tsc_pkg::RCP_W'(CRCP_L);

	tsc_pkg::series_t d_s1, d_s2;
	logic [tsc_pkg::PROD_W-1:0] sprod_s1, cprod_s1;
	logic [tsc_pkg::NUM_W:0]    snum_w, cnum_w;
	logic [tsc_pkg::NUM_W-1:0]  snum, cnum;
	logic [tsc_pkg::PP_W-1:0]   slo_s2, shi_s2, clo_s2, chi_s2;
	logic [tsc_pkg::FULL_W-1:0] sfull, cfull;
	logic [tsc_pkg::MAG_W-1:0]  snext, cnext;
	tsc_pkg::series_t nx;

	// stage 1: mag*x2 in Q.52
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1     <= d;
			sprod_s1 <= tsc_pkg::PROD_W'(d.smag) * tsc_pkg::PROD_W'(d.x2);
			cprod_s1 <= tsc_pkg::PROD_W'(d.cmag) * tsc_pkg::PROD_W'(d.x2);
		end
	end

	// (P + kk<<23) / (kk<<24) == ((P>>23) + kk) / (2kk), rounded half up
	always_comb begin
		snum_w = {1'b0, sprod_s1[tsc_pkg::PROD_W-1:23]} + (tsc_pkg::NUM_W+1)'(SKK);
		cnum_w = {1'b0, cprod_s1[tsc_pkg::PROD_W-1:23]} + (tsc_pkg::NUM_W+1)'(CKK);
		snum = snum_w[tsc_pkg::NUM_W:1];
		cnum = cnum_w[tsc_pkg::NUM_W:1];
	end

	// stage 2: reciprocal multiply, split in two halves of the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2   <= d_s1;
			slo_s2 <= tsc_pkg::PP_W'(snum[tsc_pkg::LO_W-1:0]) * tsc_pkg::PP_W'(SRCP);
			shi_s2 <= tsc_pkg::PP_W'(snum[tsc_pkg::NUM_W-1:tsc_pkg::LO_W]) *
				tsc_pkg::PP_W'(SRCP);
			clo_s2 <= tsc_pkg::PP_W'(cnum[tsc_pkg::LO_W-1:0]) * tsc_pkg::PP_W'(CRCP);
			chi_s2 <= tsc_pkg::PP_W'(cnum[tsc_pkg::NUM_W-1:tsc_pkg::LO_W]) *
				tsc_pkg::PP_W'(CRCP);
		end
	end

	// stage 3: quotient and accumulation
	always_comb begin
		sfull = (tsc_pkg::FULL_W'(shi_s2) << tsc_pkg::LO_W) + tsc_pkg::FULL_W'(slo_s2);
		cfull = (tsc_pkg::FULL_W'(chi_s2) << tsc_pkg::LO_W) + tsc_pkg::FULL_W'(clo_s2);
		snext = tsc_pkg::MAG_W'(sfull >> SSH);
		cnext = tsc_pkg::MAG_W'(cfull >> CSH);
		nx = d_s2;
		if (DO_SIN) begin
			nx.smag = snext;
			if (ODD != d_s2.neg) nx.ssum = d_s2.ssum - $signed(tsc_pkg::SUM_W'(snext));
			else                 nx.ssum = d_s2.ssum + $signed(tsc_pkg::SUM_W'(snext));
		end
		if (DO_COS) begin
			nx.cmag = cnext;
			if (ODD) nx.csum = d_s2.csum - $signed(tsc_pkg::SUM_W'(cnext));
			else     nx.csum = d_s2.csum + $signed(tsc_pkg::SUM_W'(cnext));
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end
endmodule
`default_nettype wire

>>> rtl/tsc_div_cell.sv
// One restoring-divider cell: one quotient bit of the tangent per stage
`default_nettype none
module tsc_div_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [15:0]   divisor,
	input  wire logic          num_bit,
	input  wire tsc_pkg::div_t d,
	output tsc_pkg::div_t      q
);
	logic [tsc_pkg::Q_W-1:0] trial;
	tsc_pkg::div_t nx;

	always_comb begin
		nx = d;
		trial = {d.rem[tsc_pkg::Q_W-2:0], num_bit};
		if (trial >= tsc_pkg::Q_W'(divisor)) begin
			nx.rem = trial - tsc_pkg::Q_W'(divisor);
			nx.quo = {d.quo[tsc_pkg::Q_W-2:0], 1'b1};
		end else begin
			nx.rem = trial;
			nx.quo = {d.quo[tsc_pkg::Q_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end
endmodule
`default_nettype wire

>>> rtl/taylor_sine_cosine_tangent.sv
// Top level: Taylor sine, cosine and tangent pipeline
// One angle (signed Q3.12) enters per clock and its sine, cosine (Q2.14) and
// tangent (Q12.12) leave after one stage for the square, the series cells
// of three stages each (product, reciprocal multiply, accumulate), one
// rounding stage, 30 divider cells, one quotient bit each, plus the output
// register. A stall on the result side freezes the whole row; throughput is
// one per cycle.
`default_nettype none
`include "taylor_sine_cosine_tangent_defines.svh"
module taylor_sine_cosine_tangent #(
	parameter int SINE_TERMS   = 6,
	parameter int COSINE_TERMS = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tsc_if.sink       in_ch,
	tsc_if.source     out_ch
);
	localparam int NCELL = (SINE_TERMS > COSINE_TERMS ? SINE_TERMS : COSINE_TERMS) - 1;
	localparam int NDIV  = tsc_pkg::Q_W;
	localparam int LAT   = NCELL * tsc_pkg::CELL_STAGES + NDIV + 3;

	logic en;
	logic [LAT-1:0] vld_q;

	// whole row advances unless the output holds a result not taken
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	// stage 0: magnitude, square and first terms
	tsc_pkg::series_t s0;
	tsc_pkg::series_t cell_q [NCELL+1];
	logic [14:0] raw;
	always_comb begin
		raw = in_ch.data[14:0];
		s0.neg = raw[14];
		s0.ax  = raw[14] ? 15'(16'h8000 - {1'b0, raw}) : raw;
		s0.x2  = tsc_pkg::X2_W'(s0.ax) * tsc_pkg::X2_W'(s0.ax);
		s0.smag = tsc_pkg::MAG_W'(s0.ax) << 16;
		s0.cmag = tsc_pkg::MAG_W'(1) << 28;
		s0.ssum = s0.neg ? -$signed(tsc_pkg::SUM_W'(s0.smag)) :
			$signed(tsc_pkg::SUM_W'(s0.smag));
		s0.csum = $signed(tsc_pkg::SUM_W'(s0.cmag));
	end
	always_ff @(posedge clk) begin
		if (en) cell_q[0] <= s0;
	end

	for (genvar i = 1; i <= NCELL; i++) begin : g_cell
		tsc_term_cell #(.N(i), .DO_SIN(i < SINE_TERMS), .DO_COS(i < COSINE_TERMS)) u_cell (
			.clk(clk), .en(en), .d(cell_q[i-1]), .q(cell_q[i])
		);
	end

	// round to Q.14 half away from zero and saturate
	function automatic logic signed [15:0] to_q14(input logic signed [tsc_pkg::SUM_W-1:0] s);
		logic [tsc_pkg::SUM_W-1:0] m;
		logic [tsc_pkg::SUM_W-1:0] r;
		m = s[tsc_pkg::SUM_W-1] ? tsc_pkg::SUM_W'(-s) : tsc_pkg::SUM_W'(s);
		r = (m + (tsc_pkg::SUM_W'(1) << 13)) >> 14;
		if (s[tsc_pkg::SUM_W-1]) return (r > 32768) ? 16'sh8000 : 16'(-r);
		return (r > 32767) ? 16'sh7fff : 16'(r);
	endfunction

	tsc_pkg::div_t d0;
	tsc_pkg::div_t div_q [NDIV+1];
	logic [15:0] ac_q [NDIV+1];
	logic [15:0] as_q [NDIV+1];
	logic signed [15:0] s_r, c_r;
	always_comb begin
		s_r = to_q14(cell_q[NCELL].ssum);
		c_r = to_q14(cell_q[NCELL].csum);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			div_q[0] <= '{sine: s_r, cosine: c_r, rem: '0, quo: '0};
			as_q[0] <= s_r[15] ? 16'(-s_r) : 16'(s_r);
			ac_q[0] <= c_r[15] ? 16'(-c_r) : 16'(c_r);
		end
	end
	assign d0 = div_q[0];

	// numerator is |s| << 13 (29 bits), shifted in MSB first; 30-bit quotient
	for (genvar j = 1; j <= NDIV; j++) begin : g_div
		logic [29:0] numer;
		assign numer = {1'b0, as_q[j-1], 13'b0};
		tsc_div_cell u_div (
			.clk(clk), .en(en), .divisor(ac_q[j-1]),
			.num_bit(numer[NDIV-j]), .d(div_q[j-1]), .q(div_q[j])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				as_q[j] <= as_q[j-1];
				ac_q[j] <= ac_q[j-1];
			end
		end
	end

	// final: round quotient, sign, saturate
	tsc_pkg::div_t df;
	logic [tsc_pkg::Q_W-1:0] qr;
	logic tneg;
	logic signed [23:0] tan_c;
	always_comb begin
		df = div_q[NDIV];
		qr = (df.quo + 30'd1) >> 1;
		tneg = df.sine[15] != df.cosine[15];
		if (df.cosine == 16'sd0) tan_c = df.sine[15] ? 24'sh800000 : 24'sh7fffff;
		else if (tneg) tan_c = (qr > 30'd8388608) ? 24'sh800000 : 24'(-qr);
		else tan_c = (qr > 30'(tsc_pkg::TAN_MAX)) ? 24'sh7fffff : 24'(qr);
	end

	always_ff @(posedge clk) begin
		if (en) out_ch.data <= {df.sine, df.cosine, tan_c, df.cosine == 16'sd0};
	end
	assign out_ch.valid = vld_q[LAT-1];

	logic unused;
	assign unused = ^{d0.rem, d0.quo, df.rem, in_ch.data};

	`TSC_ASSERT_IMP(a_stall_no_in, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
	`TSC_ASSERT_NEXT(a_hold_out, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
	`TSC_ASSERT_IMP(a_inval_sat, clk, arst_n, out_ch.valid && out_ch.data[0], out_ch.data[24:1] == 24'h7fffff || out_ch.data[24:1] == 24'h800000)
endmodule
`default_nettype wire
